// ===== hw/rtl/ray_triangle_intersect_defines.svh =====
// Assertion macros shared by the ray/triangle intersection checker.
// Needs a clk and an active-high rst in the scope of use.
`ifndef RAY_TRIANGLE_INTERSECT_DEFINES_SVH
`define RAY_TRIANGLE_INTERSECT_DEFINES_SVH

// Same-cycle implication, quiet during reset
`define RTI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rti check failed");

// Next-cycle implication, quiet during reset
`define RTI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rti check failed");

`endif

// ===== hw/rtl/rti_pkg.sv =====
// Shared widths, types and helpers of the ray/triangle intersection pipeline.
// No dependencies.
`timescale 1ns / 1ps

package rti_pkg;

  localparam int COORD_BITS  = 16;
  localparam int RESULT_BITS = 32;
  localparam int FRAC_BITS   = 16;
  localparam int IN_W        = 3 * COORD_BITS;
  localparam int CW          = COORD_BITS + 1;
  localparam int PROD_W      = 2 * CW;
  localparam int MINOR_W     = PROD_W + 1;
  localparam int TERM_W      = CW + MINOR_W;
  localparam int DET_W       = TERM_W + 4;
  localparam int ABS_W       = DET_W;
  localparam int NUM_W       = ABS_W + FRAC_BITS;
  localparam int LIM_W       = ABS_W + RESULT_BITS;
  localparam int REM_W       = ABS_W + 1;
  localparam int DIV_STEPS   = 4;
  localparam int DIV_STAGES  = RESULT_BITS / DIV_STEPS;
  localparam int FRONT_STAGES = 7;

  typedef logic signed [CW-1:0]      coord_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [MINOR_W-1:0] minor_t;
  typedef logic signed [TERM_W-1:0]  term_t;
  typedef logic signed [DET_W-1:0]   det_t;
  typedef logic [ABS_W-1:0]          mag_t;

  typedef struct packed {
    logic parallel;
    logic hit;
    logic [2:0] neg;
    logic [2:0] ovf;
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0]       rem;
    logic [RESULT_BITS-1:0] low;
    logic [RESULT_BITS-1:0] quo;
  } div_lane_t;

  // Pull coordinate k out of a packed vector, sign-extended by one bit
  function automatic coord_t get_coord(logic [IN_W-1:0] v, int k);
    logic signed [COORD_BITS-1:0] raw;
    raw = v[k*COORD_BITS +: COORD_BITS];
    return coord_t'(raw);
  endfunction

  // Magnitude of a nonzero-range signed determinant
  function automatic mag_t mag_abs(det_t x);
    det_t n;
    n = -x;
    return x[DET_W-1] ? mag_t'(n) : mag_t'(x);
  endfunction

endpackage

// ===== hw/rtl/rti_front.sv =====
// Front pipeline: unpack, 2x2 minors, 3x3 determinants, hit test and
// divider setup. Depends on rti_pkg.
`timescale 1ns / 1ps

module rti_front import rti_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [IN_W-1:0]       ray_origin,
  input  logic [IN_W-1:0]       ray_direction,
  input  logic [IN_W-1:0]       pivot_vertex,
  input  logic [IN_W-1:0]       edge_one,
  input  logic [IN_W-1:0]       edge_two,
  output logic                  out_valid,
  output side_t                 side,
  output mag_t                  den,
  output div_lane_t [2:0]       lane
);

  logic [FRONT_STAGES-1:0] vld;

  coord_t s0_e1 [3];
  coord_t s0_e2 [3];
  coord_t s0_nd [3];
  coord_t s0_b  [3];
  coord_t s1_e1 [3];
  coord_t s1_b  [3];
  coord_t s2_e1 [3];
  coord_t s2_b  [3];
  coord_t set_x [3][3];
  coord_t set_y [3][3];
  prod_t  pa [3][3];
  prod_t  pb [3][3];
  minor_t mn [3][3];
  term_t  tp [4][3];
  det_t   nv [4];
  det_t   rest;
  logic   hit_c;
  mag_t   s5_den;
  mag_t   s5_mag [3];
  logic [2:0] s5_neg;
  logic   s5_hit;
  logic   s5_par;
  logic [NUM_W-1:0] num [3];

  // Advance the valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[FRONT_STAGES-2:0], in_valid};
    end
  end

  assign out_valid = vld[FRONT_STAGES-1];

  // Stage 0: unpack, negate direction, form origin minus pivot
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s0_e1[k] <= get_coord(edge_one, k);
        s0_e2[k] <= get_coord(edge_two, k);
        s0_nd[k] <= -get_coord(ray_direction, k);
        s0_b[k]  <= get_coord(ray_origin, k) - get_coord(pivot_vertex, k);
      end
    end
  end

  // Column pairs of the three minor sets: (e2,-d), (b,-d), (e2,b)
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      set_x[0][k] = s0_e2[k];
      set_y[0][k] = s0_nd[k];
      set_x[1][k] = s0_b[k];
      set_y[1][k] = s0_nd[k];
      set_x[2][k] = s0_e2[k];
      set_y[2][k] = s0_b[k];
    end
  end

  // Stage 1: cross products of the minors
  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < 3; s++) begin
        for (int k = 0; k < 3; k++) begin
          pa[s][k] <= prod_t'(set_x[s][(k == 0) ? 1 : 0]) *
                      prod_t'(set_y[s][(k == 2) ? 1 : 2]);
          pb[s][k] <= prod_t'(set_x[s][(k == 2) ? 1 : 2]) *
                      prod_t'(set_y[s][(k == 0) ? 1 : 0]);
        end
      end
      s1_e1 <= s0_e1;
      s1_b  <= s0_b;
    end
  end

  // Stage 2: minors
  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < 3; s++) begin
        for (int k = 0; k < 3; k++) begin
          mn[s][k] <= minor_t'(pa[s][k]) - minor_t'(pb[s][k]);
        end
      end
      s2_e1 <= s1_e1;
      s2_b  <= s1_b;
    end
  end

  // Stage 3: cofactor terms of det, alpha, gamma and t numerators
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        tp[0][k] <= term_t'(s2_e1[k]) * term_t'(mn[0][k]);
        tp[1][k] <= term_t'(s2_b[k])  * term_t'(mn[0][k]);
        tp[2][k] <= term_t'(s2_e1[k]) * term_t'(mn[1][k]);
        tp[3][k] <= term_t'(s2_e1[k]) * term_t'(mn[2][k]);
      end
    end
  end

  // Stage 4: sum the cofactor terms
  always_ff @(posedge clk) begin
    if (en) begin
      for (int q = 0; q < 4; q++) begin
        nv[q] <= det_t'(tp[q][0]) - det_t'(tp[q][1]) + det_t'(tp[q][2]);
      end
    end
  end

  // Exact hit test from signs of numerators against the determinant
  always_comb begin
    rest  = nv[0] - nv[1] - nv[2];
    hit_c = (nv[3] != '0) &&
            (nv[3][DET_W-1] == nv[0][DET_W-1]) &&
            ((nv[1] == '0) || (nv[1][DET_W-1] == nv[0][DET_W-1])) &&
            ((nv[2] == '0) || (nv[2][DET_W-1] == nv[0][DET_W-1])) &&
            ((rest == '0) || (rest[DET_W-1] == nv[0][DET_W-1]));
  end

  // Stage 5: magnitudes, quotient signs, flags
  always_ff @(posedge clk) begin
    if (en) begin
      s5_den    <= mag_abs(nv[0]);
      s5_mag[0] <= mag_abs(nv[3]);
      s5_mag[1] <= mag_abs(nv[1]);
      s5_mag[2] <= mag_abs(nv[2]);
      s5_neg[0] <= nv[3][DET_W-1] ^ nv[0][DET_W-1];
      s5_neg[1] <= nv[1][DET_W-1] ^ nv[0][DET_W-1];
      s5_neg[2] <= nv[2][DET_W-1] ^ nv[0][DET_W-1];
      s5_hit    <= hit_c;
      s5_par    <= (nv[0] == '0);
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      num[l] = {s5_mag[l], {FRAC_BITS{1'b0}}};
    end
  end

  // Stage 6: overflow check and first partial remainder
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        side.ovf[l] <= LIM_W'(num[l]) >= {s5_den, {RESULT_BITS{1'b0}}};
        lane[l].rem <= REM_W'(num[l][NUM_W-1:RESULT_BITS]);
        lane[l].low <= num[l][RESULT_BITS-1:0];
        lane[l].quo <= '0;
      end
      side.neg      <= s5_neg;
      side.hit      <= s5_hit;
      side.parallel <= s5_par;
      den           <= s5_den;
    end
  end

endmodule

// ===== hw/rtl/rti_div_stage.sv =====
// One stage of the restoring divider: DIV_STEPS quotient bits for the
// t, alpha and gamma lanes, sharing one divisor. Depends on rti_pkg.
`timescale 1ns / 1ps

module rti_div_stage import rti_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  side_t           in_side,
  input  mag_t            in_den,
  input  div_lane_t [2:0] in_lane,
  output logic            out_valid,
  output side_t           out_side,
  output mag_t            out_den,
  output div_lane_t [2:0] out_lane
);

  div_lane_t [2:0] lane_next;
  logic [REM_W-1:0] dz;

  // Shift in a numerator bit, subtract when the divisor fits
  always_comb begin
    dz = REM_W'(in_den);
    lane_next = in_lane;
    for (int l = 0; l < 3; l++) begin
      for (int s = 0; s < DIV_STEPS; s++) begin
        lane_next[l].rem = {lane_next[l].rem[REM_W-2:0], lane_next[l].low[RESULT_BITS-1]};
        lane_next[l].low = {lane_next[l].low[RESULT_BITS-2:0], 1'b0};
        if (lane_next[l].rem >= dz) begin
          lane_next[l].rem = lane_next[l].rem - dz;
          lane_next[l].quo = {lane_next[l].quo[RESULT_BITS-2:0], 1'b1};
        end else begin
          lane_next[l].quo = {lane_next[l].quo[RESULT_BITS-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // Hold on stall, advance otherwise
  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= in_side;
      out_den  <= in_den;
      out_lane <= lane_next;
    end
  end

endmodule

// ===== hw/rtl/ray_triangle_intersect.sv =====
// Ray/triangle intersection, one item per cycle while no result stall holds it, fully pipelined.
// Pipeline: 7 determinant stages, 8 divider stages of 4 quotient bits each,
// 1 output register.
// Throughput: one item every cycle; a result stall freezes the whole pipe.
// Reset (synchronous, rst high) clears all valid bits; payload is not reset.
`timescale 1ns / 1ps

module ray_triangle_intersect import rti_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          ray_valid,
  output logic                          ray_stall,
  input  logic [IN_W-1:0]               ray_origin,
  input  logic [IN_W-1:0]               ray_direction,
  input  logic [IN_W-1:0]               pivot_vertex,
  input  logic [IN_W-1:0]               edge_one,
  input  logic [IN_W-1:0]               edge_two,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          hit,
  output logic                          parallel,
  output logic signed [RESULT_BITS-1:0] hit_distance,
  output logic signed [RESULT_BITS-1:0] bary_alpha,
  output logic signed [RESULT_BITS-1:0] bary_gamma
);

  logic            adv;
  logic            st_valid [DIV_STAGES+1];
  side_t           st_side  [DIV_STAGES+1];
  mag_t            st_den   [DIV_STAGES+1];
  div_lane_t [2:0] st_lane  [DIV_STAGES+1];
  logic [RESULT_BITS-1:0] res [3];
  side_t           fin;

  // Move everything while the output register is free or being taken
  assign adv       = !(result_valid && result_stall);
  assign ray_stall = !adv;

  rti_front u_front (
    .clk          (clk),
    .rst          (rst),
    .en           (adv),
    .in_valid     (ray_valid),
    .ray_origin   (ray_origin),
    .ray_direction(ray_direction),
    .pivot_vertex (pivot_vertex),
    .edge_one     (edge_one),
    .edge_two     (edge_two),
    .out_valid    (st_valid[0]),
    .side         (st_side[0]),
    .den          (st_den[0]),
    .lane         (st_lane[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    rti_div_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .in_valid (st_valid[g]),
      .in_side  (st_side[g]),
      .in_den   (st_den[g]),
      .in_lane  (st_lane[g]),
      .out_valid(st_valid[g+1]),
      .out_side (st_side[g+1]),
      .out_den  (st_den[g+1]),
      .out_lane (st_lane[g+1])
    );
  end

  // Saturate and apply the sign of each quotient
  always_comb begin
    logic [RESULT_BITS-1:0] lim;
    logic [RESULT_BITS-1:0] mag;
    fin = st_side[DIV_STAGES];
    for (int l = 0; l < 3; l++) begin
      lim = fin.neg[l] ? {1'b1, {(RESULT_BITS-1){1'b0}}} : {1'b0, {(RESULT_BITS-1){1'b1}}};
      mag = (fin.ovf[l] || (st_lane[DIV_STAGES][l].quo > lim)) ?
            lim : st_lane[DIV_STAGES][l].quo;
      res[l] = fin.neg[l] ? (~mag + 1'b1) : mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= st_valid[DIV_STAGES];
    end
  end

  // Output register; a parallel ray reports zeros
  always_ff @(posedge clk) begin
    if (adv) begin
      parallel     <= fin.parallel;
      hit          <= fin.hit && !fin.parallel;
      hit_distance <= fin.parallel ? '0 : res[0];
      bary_alpha   <= fin.parallel ? '0 : res[1];
      bary_gamma   <= fin.parallel ? '0 : res[2];
    end
  end

endmodule

// ===== hw/rtl/rti_checker.sv =====
// Port-level checks of the ray/triangle intersection block, bound to the top.
// Depends on rti_pkg and ray_triangle_intersect_defines.svh.
`timescale 1ns / 1ps
`include "ray_triangle_intersect_defines.svh"

module rti_checker import rti_pkg::*; (
  input logic                          clk,
  input logic                          rst,
  input logic                          result_valid,
  input logic                          result_stall,
  input logic                          hit,
  input logic                          parallel,
  input logic signed [RESULT_BITS-1:0] hit_distance,
  input logic signed [RESULT_BITS-1:0] bary_alpha,
  input logic signed [RESULT_BITS-1:0] bary_gamma
);

  // A parallel ray never hits
  `RTI_ASSERT_NOW(a_par_no_hit, result_valid && parallel, !hit)

  // A parallel ray reports all-zero values
  `RTI_ASSERT_NOW(a_par_zero, result_valid && parallel, (hit_distance == '0) && (bary_alpha == '0) && (bary_gamma == '0))

  // A hit has nonnegative distance and weights
  `RTI_ASSERT_NOW(a_hit_signs, result_valid && hit, !hit_distance[RESULT_BITS-1] && !bary_alpha[RESULT_BITS-1] && !bary_gamma[RESULT_BITS-1])

  // A stalled result item holds
  `RTI_ASSERT_NEXT(a_hold, result_valid && result_stall, result_valid && $stable(hit_distance) && $stable(hit))

endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (
  .clk         (clk),
  .rst         (rst),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .hit         (hit),
  .parallel    (parallel),
  .hit_distance(hit_distance),
  .bary_alpha  (bary_alpha),
  .bary_gamma  (bary_gamma)
);

// ===== dv/tb_ray_triangle_intersect.sv =====
// Testbench for ray_triangle_intersect: directed and random ray/triangle items,
// each result checked against an exact integer intersection predictor or a typed-in result.
// Depends on rti_pkg and the ray_triangle_intersect RTL.
`timescale 1ns / 1ps

module tb_ray_triangle_intersect;
  import rti_pkg::*;

  typedef logic [IN_W-1:0] vec_t;
  typedef logic signed [RESULT_BITS-1:0] fix_t;

  typedef struct {
    vec_t o, d, p, e1, e2;
  } ray_item_t;

  typedef struct {
    logic hit;
    logic parallel;
    fix_t tdist;
    fix_t alpha;
    fix_t gamma;
  } isect_t;

  // One directed row: item plus an optional typed-in result
  typedef struct {
    ray_item_t item;
    bit        fixed;
    isect_t    res;
  } stim_row_t;

  logic clk, rst;
  logic ray_valid, ray_stall;
  vec_t ray_origin, ray_direction, pivot_vertex, edge_one, edge_two;
  logic result_valid, result_stall;
  logic hit, parallel;
  fix_t hit_distance, bary_alpha, bary_gamma;

  isect_t isect_q[$];
  int     err_cnt;

  ray_triangle_intersect u_top (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("tb_ray_triangle_intersect: done, errors");
    $finish;
  end

  // Vector from three signed coordinates, x low
  function automatic vec_t mk_vec(int x, int y, int z);
    return {z[15:0], y[15:0], x[15:0]};
  endfunction

  // Coordinate k as a signed 64-bit value
  function automatic longint crd(vec_t v, int k);
    logic signed [15:0] r;
    r = v[k*16 +: 16];
    return longint'(r);
  endfunction

  // Determinant of the matrix with columns a, b, c
  function automatic logic signed [127:0] det_cols(longint a[3], longint b[3],
                                                   longint c[3]);
    logic signed [127:0] m0, m1, m2;
    m0 = 128'(b[1] * c[2] - b[2] * c[1]);
    m1 = 128'(b[0] * c[2] - b[2] * c[0]);
    m2 = 128'(b[0] * c[1] - b[1] * c[0]);
    return 128'(a[0]) * m0 - 128'(a[1]) * m1 + 128'(a[2]) * m2;
  endfunction

  // Fixed-point ratio, truncated toward zero, saturated
  function automatic fix_t fix_ratio(logic signed [127:0] num, logic signed [127:0] den);
    logic signed [127:0] q;
    q = (num <<< FRAC_BITS) / den;
    if (q > 128'sh7fffffff) return 32'h7fffffff;
    if (q < -128'sh80000000) return 32'h80000000;
    return q[31:0];
  endfunction

  function automatic bit same_side(logic signed [127:0] x, logic signed [127:0] den);
    return (x == 0) || ((x < 0) == (den < 0));
  endfunction

  // Solve [E1 E2 -D](alpha, gamma, t) = O - P
  function automatic isect_t solve_isect(ray_item_t it);
    longint o[3], nd[3], e1[3], e2[3], b[3];
    logic signed [127:0] dt, na, ng, nt, rest;
    isect_t r;
    for (int k = 0; k < 3; k++) begin
      o[k] = crd(it.o, k);
      nd[k] = -crd(it.d, k);
      e1[k] = crd(it.e1, k);
      e2[k] = crd(it.e2, k);
      b[k] = o[k] - crd(it.p, k);
    end
    r = '{1'b0, 1'b0, '0, '0, '0};
    dt = det_cols(e1, e2, nd);
    if (dt == 0) begin
      r.parallel = 1'b1;
      return r;
    end
    na = det_cols(b, e2, nd);
    ng = det_cols(e1, b, nd);
    nt = det_cols(e1, e2, b);
    rest = dt - na - ng;
    r.hit = nt != 0 && same_side(nt, dt) && same_side(na, dt) && same_side(ng, dt)
            && same_side(rest, dt);
    r.tdist = fix_ratio(nt, dt);
    r.alpha = fix_ratio(na, dt);
    r.gamma = fix_ratio(ng, dt);
    return r;
  endfunction

  function automatic int gap_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return 0;
    if (sel < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one item and hold it until accepted; valid stays up for a
  // back-to-back item and drops only for a gap
  task automatic send_item(ray_item_t it, isect_t exp_res);
    int g;
    g = gap_len();
    if (g > 0) begin
      ray_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    ray_origin <= it.o;
    ray_direction <= it.d;
    pivot_vertex <= it.p;
    edge_one <= it.e1;
    edge_two <= it.e2;
    ray_valid <= 1'b1;
    @(posedge clk);
    while (ray_stall) @(posedge clk);
    isect_q.push_back(exp_res);
    @(negedge clk);
  endtask

  function automatic vec_t rnd_vec(int mode);
    case (mode)
      0: return IN_W'({$urandom, $urandom});
      1: return mk_vec($urandom_range(0, 1024) - 512, $urandom_range(0, 1024) - 512,
                       $urandom_range(0, 1024) - 512);
      default: return mk_vec($urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4,
                             $urandom_range(0, 8) - 4);
    endcase
  endfunction

  // Well-formed ray aimed at a point inside or near the triangle
  function automatic ray_item_t aimed_item();
    ray_item_t it;
    int a, g, t, m;
    m = $urandom_range(1, 2);
    it.p = rnd_vec(m);
    it.e1 = rnd_vec(m);
    it.e2 = rnd_vec(m);
    it.d = rnd_vec(m);
    a = $urandom_range(0, 12) - 2;
    g = $urandom_range(0, 12) - 2;
    t = $urandom_range(0, 8) - 2;
    for (int k = 0; k < 3; k++)
      it.o[k*16 +: 16] = 16'((crd(it.p, k) * 8 + a * crd(it.e1, k) + g * crd(it.e2, k)
                              - t * crd(it.d, k)) / 8);
    return it;
  endfunction

  // Receiver: random stalls, field-by-field compare
  initial begin
    isect_t ex;
    result_stall = 1'b1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 199) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(10, 40)) @(negedge clk);
      end
      result_stall <= ($urandom_range(0, 99) < 25) ? 1'b1 : 1'b0;
      @(posedge clk);
      if (result_valid && !result_stall) begin
        if (isect_q.size() == 0) begin
          $error("unexpected item: hit=%0b parallel=%0b", hit, parallel);
          err_cnt++;
        end else begin
          ex = isect_q.pop_front();
          if (hit !== ex.hit) begin
            $error("hit: expected %0b, got %0b", ex.hit, hit); err_cnt++;
          end
          if (parallel !== ex.parallel) begin
            $error("parallel: expected %0b, got %0b", ex.parallel, parallel); err_cnt++;
          end
          if (hit_distance !== ex.tdist) begin
            $error("hit_distance: expected %h, got %h", ex.tdist, hit_distance); err_cnt++;
          end
          if (bary_alpha !== ex.alpha) begin
            $error("bary_alpha: expected %h, got %h", ex.alpha, bary_alpha); err_cnt++;
          end
          if (bary_gamma !== ex.gamma) begin
            $error("bary_gamma: expected %h, got %h", ex.gamma, bary_gamma); err_cnt++;
          end
        end
      end
      @(negedge clk);
    end
  end

  // Stimulus
  initial begin
    stim_row_t rows[$];
    ray_item_t it;
    isect_t zero_par;
    int wait_cyc;
    err_cnt = 0;
    rst = 1'b1;
    ray_valid = 1'b0;
    ray_origin = '0; ray_direction = '0; pivot_vertex = '0;
    edge_one = '0; edge_two = '0;
    zero_par = '{1'b0, 1'b1, '0, '0, '0};

    // Directed rows: parallel cases and the first two hit cases carry a typed-in result
    rows.push_back('{'{'0, '0, '0, '0, '0}, 1'b1, zero_par});
    rows.push_back('{'{'1, '1, '1, '1, '1}, 1'b1, zero_par});
    rows.push_back('{'{mk_vec(0, 0, 256), mk_vec(256, 0, 0), '0,
                     mk_vec(256, 0, 0), mk_vec(0, 256, 0)}, 1'b1, zero_par});
    // Unit triangle, ray straight down: hit, on vertex, on edge, outside, behind, t=0
    rows.push_back('{'{mk_vec(64, 64, 256), mk_vec(0, 0, -256), '0,
                     mk_vec(256, 0, 0), mk_vec(0, 256, 0)}, 1'b1,
                     '{1'b1, 1'b0, 32'h10000, 32'h4000, 32'h4000}});
    rows.push_back('{'{mk_vec(0, 0, 256), mk_vec(0, 0, -256), '0,
                     mk_vec(256, 0, 0), mk_vec(0, 256, 0)}, 1'b1,
                     '{1'b1, 1'b0, 32'h10000, 32'h0, 32'h0}});
    rows.push_back('{'{mk_vec(128, 128, 256), mk_vec(0, 0, -256), '0,
                     mk_vec(256, 0, 0), mk_vec(0, 256, 0)}, 1'b0, zero_par});
    rows.push_back('{'{mk_vec(200, 200, 256), mk_vec(0, 0, -256), '0,
                     mk_vec(256, 0, 0), mk_vec(0, 256, 0)}, 1'b0, zero_par});
    rows.push_back('{'{mk_vec(64, 64, -256), mk_vec(0, 0, -256), '0,
                     mk_vec(256, 0, 0), mk_vec(0, 256, 0)}, 1'b0, zero_par});
    rows.push_back('{'{mk_vec(64, 64, 0), mk_vec(0, 0, -256), '0,
                     mk_vec(256, 0, 0), mk_vec(0, 256, 0)}, 1'b0, zero_par});
    // Saturation: tiny determinant, huge offsets
    rows.push_back('{'{mk_vec(32767, 32767, 32767), mk_vec(0, 0, -1),
                     mk_vec(-32768, -32768, -32768), mk_vec(1, 0, 0),
                     mk_vec(0, 1, 0)}, 1'b0, zero_par});
    rows.push_back('{'{mk_vec(-32768, -32768, -32768), mk_vec(0, 0, 1),
                     mk_vec(32767, 32767, 32767), mk_vec(1, 0, 0),
                     mk_vec(0, 1, 0)}, 1'b0, zero_par});
    rows.push_back('{'{mk_vec(-32768, 32767, -32768), mk_vec(-32768, -32768, 32767),
                     mk_vec(32767, -32768, 32767), mk_vec(-32768, 32767, 32767),
                     mk_vec(32767, 32767, -32768)}, 1'b0, zero_par});
    rows.push_back('{'{48'h8000_7fff_8000, 48'h7fff_8000_0001, 48'h0001_8000_7fff,
                     48'hffff_0001_8000, 48'h8000_ffff_0001}, 1'b0, zero_par});

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i])
      send_item(rows[i].item, rows[i].fixed ? rows[i].res : solve_isect(rows[i].item));

    // Random part; pause once mid-run until the pipe drains
    for (int n = 0; n < 1000; n++) begin
      if (n == 500) begin
        ray_valid <= 1'b0;
        @(negedge clk);
        while (isect_q.size() != 0) @(negedge clk);
      end
      case ($urandom_range(0, 9))
        0, 1: begin
          it.o = rnd_vec(0); it.d = rnd_vec(0); it.p = rnd_vec(0);
          it.e1 = rnd_vec(0); it.e2 = rnd_vec(0);
        end
        2: begin
          it = aimed_item();
          it.e2 = it.e1;
        end
        default: it = aimed_item();
      endcase
      send_item(it, solve_isect(it));
    end
    ray_valid <= 1'b0;

    wait_cyc = 0;
    while (isect_q.size() != 0 && wait_cyc < 100000) begin
      @(negedge clk);
      wait_cyc++;
    end
    repeat (40) @(negedge clk);
    if (err_cnt == 0 && isect_q.size() == 0)
      $display("tb_ray_triangle_intersect: done, clean");
    else
      $display("tb_ray_triangle_intersect: done, errors");
    $finish;
  end

endmodule
